// File: rtl/core/tas_pkg.sv
// Shared types, codes and constants of the timed action sequencer.
package tas_pkg;

    // Milliseconds per second for the register scaling
    localparam int MS_PER_SEC      = 1000;
    // Default number of table steps
    localparam int MAX_STEPS_DEF   = 8;
    // Step table slots reachable through the 3-bit slot field
    localparam int SLOT_W          = 3;
    localparam int SLOT_LIMIT      = 8;

    // Register widths
    localparam int INTERVAL_W      = 17;
    localparam int DURATION_W      = 23;
    localparam int REPS_W          = 16;
    localparam int STEPS_W         = 4;
    localparam int CFG_DATA_W      = 23;
    localparam int CFG_IDX_W       = 2;
    localparam int INTERVAL_MS_W   = 27;
    localparam int DURATION_MS_W   = 33;

    // Payload widths
    localparam int MS_W            = 32;
    localparam int SHOTS_W         = 16;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 56;
    localparam logic [SHOTS_W-1:0] SHOTS_MAX = '1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_LOAD  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_STOPPED = 2'd1,
        EV_PENDING = 2'd2,
        EV_FIRED   = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERVAL = 2'd0,
        REG_DURATION = 2'd1,
        REG_REPS     = 2'd2,
        REG_STEPS    = 2'd3
    } cfg_idx_t;

    // Configuration as the timer core sees it, already scaled to ms
    typedef struct packed {
        logic [INTERVAL_MS_W-1:0] interval_ms;
        logic [DURATION_MS_W-1:0] duration_ms;
        logic [REPS_W-1:0]        reps;
        logic [STEPS_W-1:0]       step_count;
    } cfg_t;

    typedef struct packed {
        logic [MS_W-1:0] offset_ms;
        logic            relative;
    } tab_entry_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_W-1:0]    slot;
        tab_entry_t           entry;
    } tab_wr_t;

    typedef struct packed {
        opcode_t           op;
        logic [SLOT_W-1:0] slot;
        tab_entry_t        entry;
    } item_t;

    typedef struct packed {
        logic                fired;
        logic [2:0]          fired_step;
        logic                running;
        logic                stopping;
        event_t              event_res;
        logic [SHOTS_W-1:0]  shots_done;
        logic [MS_W-1:0]     ms_to_next;
    } result_t;

endpackage

// File: rtl/core/tas_cfg_regs.sv
// Configuration registers of the sequencer, stored scaled to milliseconds.
module tas_cfg_regs
    import tas_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write and scale the time registers once, at write time
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_index))
                REG_INTERVAL: cfg_next.interval_ms =
                    INTERVAL_MS_W'(INTERVAL_MS_W'(cfg_wdata[INTERVAL_W-1:0]) *
                                   INTERVAL_MS_W'(MS_PER_SEC));
                REG_DURATION: cfg_next.duration_ms =
                    DURATION_MS_W'(DURATION_MS_W'(cfg_wdata[DURATION_W-1:0]) *
                                   DURATION_MS_W'(MS_PER_SEC));
                REG_REPS:     cfg_next.reps       = cfg_wdata[REPS_W-1:0];
                REG_STEPS:    cfg_next.step_count = cfg_wdata[STEPS_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/tas_step_table.sv
// Step offset table: one write port, one combinational read of flop storage.
module tas_step_table
    import tas_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int POS_W     = $clog2(MAX_STEPS + 1)
) (
    input  logic             aclk,
    input  tab_wr_t          tab_wr,
    input  logic [POS_W-1:0] rd_addr,
    output tab_entry_t       rd_entry
);

    localparam int TAB_DEPTH = (MAX_STEPS < SLOT_LIMIT) ? MAX_STEPS : SLOT_LIMIT;
    localparam int TAB_AW    = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;

    tab_entry_t tab_reg [TAB_DEPTH];

    // Drop loads to slots past the table
    always_ff @(posedge aclk) begin
        if (tab_wr.en && (32'(tab_wr.slot) < TAB_DEPTH)) begin
            tab_reg[tab_wr.slot[TAB_AW-1:0]] <= tab_wr.entry;
        end
    end

    assign rd_entry = tab_reg[rd_addr[TAB_AW-1:0]];

endmodule

// File: rtl/core/tas_timer_core.sv
// Sequencer state and the single-pass update for one transaction.
module tas_timer_core
    import tas_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF,
    parameter int POS_W     = $clog2(MAX_STEPS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             proc_en,
    input  item_t            item,
    input  cfg_t             cfg,
    input  tab_entry_t       tab_entry,
    output logic [POS_W-1:0] tab_rd_addr,
    output result_t          result
);

    logic [MS_W-1:0]    now_ms_reg,   now_ms_next;
    logic [MS_W-1:0]    start_ms_reg, start_ms_next;
    logic [MS_W-1:0]    cycle_ms_reg, cycle_ms_next;
    logic [MS_W-1:0]    next_ms_reg,  next_ms_next;
    logic               idle_reg,     idle_next;
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [SHOTS_W-1:0] shots_reg,    shots_next;
    logic               run_reg,      run_next;
    logic               pend_reg,     pend_next;

    logic [POS_W-1:0]   n_steps;
    logic               is_start;
    logic [MS_W-1:0]    now_n;
    logic               b_idle;
    logic [POS_W-1:0]   b_pos;
    logic [MS_W-1:0]    b_cycle;
    logic [SHOTS_W-1:0] b_shots;
    logic               b_pend;
    logic [POS_W-1:0]   adv_idx;
    logic [SHOTS_W-1:0] shots_inc;
    logic [MS_W-1:0]    cycle_add;
    logic [MS_W-1:0]    since_ms;
    logic               dur_hit;
    logic               due;
    logic               do_adv;
    logic               do_stopreq;
    logic               do_halt;
    logic               fire;
    event_t             ev;

    // Base values: a start clears the position and counters first
    always_comb begin
        n_steps  = (32'(cfg.step_count) > MAX_STEPS) ? POS_W'(MAX_STEPS)
                                                     : POS_W'(cfg.step_count);
        is_start = (item.op == OP_START);
        now_n    = (item.op == OP_TICK) ? now_ms_reg + 1'b1 : now_ms_reg;
        b_idle   = is_start ? 1'b1 : idle_reg;
        b_pos    = is_start ? '0 : pos_reg;
        b_cycle  = is_start ? now_ms_reg : cycle_ms_reg;
        b_shots  = is_start ? '0 : shots_reg;
        b_pend   = is_start ? 1'b0 : pend_reg;
        adv_idx  = b_idle ? '0 : b_pos + 1'b1;
        shots_inc = (b_shots == SHOTS_MAX) ? b_shots : b_shots + 1'b1;
        cycle_add = b_cycle + MS_W'(cfg.interval_ms);
        since_ms  = now_n - start_ms_reg;
        dur_hit   = (cfg.duration_ms != '0) && ({1'b0, since_ms} >= cfg.duration_ms);
        due       = (now_n >= next_ms_reg);
    end

    assign tab_rd_addr = adv_idx;

    // Next state for one processed transaction
    always_comb begin
        now_ms_next   = now_ms_reg;
        start_ms_next = start_ms_reg;
        cycle_ms_next = cycle_ms_reg;
        next_ms_next  = next_ms_reg;
        idle_next     = idle_reg;
        pos_next      = pos_reg;
        shots_next    = shots_reg;
        run_next      = run_reg;
        pend_next     = pend_reg;
        do_adv        = 1'b0;
        do_stopreq    = 1'b0;
        do_halt       = 1'b0;
        fire          = 1'b0;
        ev            = EV_NONE;

        if (proc_en) begin
            unique case (item.op)
                OP_TICK: begin
                    now_ms_next = now_n;
                    if (run_reg) begin
                        if (dur_hit) begin
                            do_stopreq = 1'b1;
                        end else if (due) begin
                            do_adv = 1'b1;
                        end
                    end
                end
                OP_START: begin
                    if (n_steps == '0) begin
                        do_halt = 1'b1;
                    end else begin
                        start_ms_next = now_ms_reg;
                        cycle_ms_next = now_ms_reg;
                        shots_next    = '0;
                        run_next      = 1'b1;
                        pend_next     = 1'b0;
                        do_adv        = 1'b1;
                    end
                end
                OP_STOP: begin
                    if (run_reg) begin
                        do_stopreq = 1'b1;
                    end else begin
                        do_halt = 1'b1;
                    end
                end
                OP_LOAD: begin
                    do_adv = 1'b0;
                end
                default: begin
                    do_adv = 1'b0;
                end
            endcase

            // Advance: fire the current step, then schedule the next one
            if (do_adv) begin
                if (!b_idle && (b_pos < n_steps)) begin
                    fire = 1'b1;
                    ev   = EV_FIRED;
                end
                if (adv_idx >= n_steps) begin
                    shots_next = shots_inc;
                    idle_next  = 1'b1;
                    pos_next   = '0;
                    if (b_pend || ((cfg.reps != '0) && (shots_inc >= cfg.reps))) begin
                        do_halt = 1'b1;
                    end else begin
                        cycle_ms_next = (now_n > cycle_add) ? now_n : cycle_add;
                        next_ms_next  = (now_n > cycle_add) ? now_n : cycle_add;
                    end
                end else begin
                    idle_next    = 1'b0;
                    pos_next     = adv_idx;
                    next_ms_next = (tab_entry.relative ? now_n : b_cycle) +
                                   tab_entry.offset_ms;
                end
            end

            // Stop request: immediate between cycles or when already pending
            if (do_stopreq) begin
                if (b_idle || b_pend) begin
                    do_halt = 1'b1;
                end else begin
                    pend_next = 1'b1;
                    ev        = EV_PENDING;
                end
            end

            if (do_halt) begin
                run_next      = 1'b0;
                pend_next     = 1'b0;
                start_ms_next = '0;
                ev            = EV_STOPPED;
            end
        end
    end

    // Result fields
    always_comb begin
        result.fired      = fire;
        result.fired_step = fire ? 3'(b_pos) : 3'd0;
        result.running    = run_next;
        result.stopping   = pend_next;
        result.event_res  = ev;
        result.shots_done = shots_next;
        result.ms_to_next = (run_next && (now_ms_next < next_ms_next)) ?
                            next_ms_next - now_ms_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_ms_reg   <= '0;
            start_ms_reg <= '0;
            cycle_ms_reg <= '0;
            next_ms_reg  <= '0;
            idle_reg     <= 1'b1;
            pos_reg      <= '0;
            shots_reg    <= '0;
            run_reg      <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            now_ms_reg   <= now_ms_next;
            start_ms_reg <= start_ms_next;
            cycle_ms_reg <= cycle_ms_next;
            next_ms_reg  <= next_ms_next;
            idle_reg     <= idle_next;
            pos_reg      <= pos_next;
            shots_reg    <= shots_next;
            run_reg      <= run_next;
            pend_reg     <= pend_next;
        end
    end

    // A pending stop exists only while running
    a_pend_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> run_reg)
        else $error("stop pending while sequencer stopped");

    // Between cycles the position rests at zero
    a_idle_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        idle_reg |-> (pos_reg == '0))
        else $error("idle position not cleared");

    // The position never runs past the table
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < MAX_STEPS)
        else $error("step position out of range");

    // A successful start leaves the shot count cleared or at one
    a_start_shots: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_en && is_start && (n_steps != '0)) |=> (shots_reg <= SHOTS_W'(1)))
        else $error("start did not clear the shot count");

endmodule

// File: rtl/core/timed_action_sequencer.sv
// Top level of the timed action sequencer: stream ports, input and result registers.
//
// Usage:
//   The slave stream carries one command per transaction, selected by s_tuser:
//   tick one millisecond, start, stop after last step, or load a table step.
//   Every accepted transaction produces exactly one result transaction on the
//   master stream with the fired step, run status, event code, shot count and
//   the time left to the next step.
//   The plain write port sets interval, duration, repetitions and step count;
//   write it only while no transaction is in flight.
//   Pipeline: a transaction accepted into the input register is processed
//   once the result register is free or being taken, and its result is
//   then captured in and presented from the result register.
//   Throughput: one transaction per cycle unless stalled; the whole update
//   is one pass through the timer core between the input and result registers.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more transaction, then s_tready drops.
//   Reset (synchronous, aresetn low) clears the clock, counters, run state
//   and registers; the step table keeps no reset and must be loaded.
module timed_action_sequencer
    import tas_pkg::*;
#(
    parameter int MAX_STEPS = MAX_STEPS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // Command stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [2:0] step_slot, [34:3] step_offset_ms, [35] step_relative, [39:36] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [1:0] opcode
    input  logic [1:0]            s_tuser,
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] fired, [3:1] fired_step, [4] running, [5] stopping,
    // [21:6] shots_done, [53:22] ms_to_next, [55:54] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // [1:0] event_res
    output logic [1:0]            m_tuser
);

    localparam int POS_W = $clog2(MAX_STEPS + 1);

    logic             in_valid_reg, in_valid_next;
    item_t            in_item_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          out_res_reg;
    logic             advance;
    logic             proc_en;
    cfg_t             cfg;
    tab_wr_t          tab_wr;
    tab_entry_t       tab_entry;
    logic [POS_W-1:0] tab_rd_addr;
    result_t          result;

    // Move the pipeline when the result register is free or being taken
    assign advance  = !out_valid_reg || m_tready;
    assign proc_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = (s_tvalid && s_tready) ? 1'b1 : (in_valid_reg && !advance);
    assign out_valid_next = proc_en || (out_valid_reg && !m_tready);

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.op              <= opcode_t'(s_tuser);
            in_item_reg.slot            <= s_tdata[2:0];
            in_item_reg.entry.offset_ms <= s_tdata[34:3];
            in_item_reg.entry.relative  <= s_tdata[35];
        end
    end

    // Table load from the processed transaction
    always_comb begin
        tab_wr.en    = proc_en && (in_item_reg.op == OP_LOAD);
        tab_wr.slot  = in_item_reg.slot;
        tab_wr.entry = in_item_reg.entry;
    end

    tas_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tas_step_table #(
        .MAX_STEPS (MAX_STEPS),
        .POS_W     (POS_W)
    ) u_table (
        .aclk     (aclk),
        .tab_wr   (tab_wr),
        .rd_addr  (tab_rd_addr),
        .rd_entry (tab_entry)
    );

    tas_timer_core #(
        .MAX_STEPS (MAX_STEPS),
        .POS_W     (POS_W)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .proc_en     (proc_en),
        .item        (in_item_reg),
        .cfg         (cfg),
        .tab_entry   (tab_entry),
        .tab_rd_addr (tab_rd_addr),
        .result      (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_en) begin
            out_res_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.ms_to_next, out_res_reg.shots_done,
                       out_res_reg.stopping, out_res_reg.running,
                       out_res_reg.fired_step, out_res_reg.fired};
    assign m_tuser  = out_res_reg.event_res;

endmodule

// File: sim/tb.sv
// Self-checking testbench for the timed action sequencer stream block.
module tb
    import tas_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 60;
    localparam int IDLE_PCT      = 31;

    typedef struct {
        bit                     cfg_row;
        logic [INTERVAL_W-1:0]  intv;
        logic [DURATION_W-1:0]  dur;
        logic [REPS_W-1:0]      reps;
        logic [STEPS_W-1:0]     steps;
        item_t                  cmd;
        bit                     typed;
        result_t                want;
    } plan_row_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [1:0]            m_tuser;

    // Predicted sequencer state and register mirror
    logic [INTERVAL_W-1:0] reg_interval = '0;
    logic [DURATION_W-1:0] reg_duration = '0;
    logic [REPS_W-1:0]     reg_reps     = '0;
    logic [STEPS_W-1:0]    reg_steps    = '0;
    logic [MS_W-1:0]       clk_ms       = '0;
    logic [MS_W-1:0]       run_start_ms = '0;
    logic [MS_W-1:0]       cyc_ms       = '0;
    logic [MS_W-1:0]       due_ms       = '0;
    logic                  at_lead_in   = 1'b1;
    logic [3:0]            pos          = '0;
    logic [SHOTS_W-1:0]    shots        = '0;
    logic                  active       = 1'b0;
    logic                  stop_req     = 1'b0;
    logic [MS_W-1:0]       tab_off [SLOT_LIMIT];
    logic                  tab_rel [SLOT_LIMIT];
    result_t               res_now;

    result_t     results_due [$];
    plan_row_t   plan [26];
    int unsigned errors    = 0;
    int unsigned cycle_count = 0;
    int          hold_left = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    bit          idle_on   = 1'b1;

    timed_action_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ---------------- timer prediction ----------------

    function automatic int unsigned steps_used();
        return (reg_steps > MAX_STEPS_DEF) ? MAX_STEPS_DEF : reg_steps;
    endfunction

    function automatic void go_idle();
        active       = 1'b0;
        stop_req     = 1'b0;
        run_start_ms = '0;
        res_now.event_res = EV_STOPPED;
    endfunction

    // Fire the current step if any, then schedule the next one or close the cycle
    function automatic void step_ahead();
        int unsigned n;
        int unsigned idx;
        logic [2:0]  k;
        n = steps_used();
        if (!at_lead_in && pos < n) begin
            res_now.fired      = 1'b1;
            res_now.fired_step = pos[2:0];
            res_now.event_res  = EV_FIRED;
        end
        idx = at_lead_in ? 0 : pos + 1;
        at_lead_in = 1'b0;
        pos = idx[3:0];
        if (idx >= n) begin
            if (shots != SHOTS_MAX) shots++;
            at_lead_in = 1'b1;
            pos = '0;
            if (stop_req || (reg_reps != 0 && shots >= reg_reps)) begin
                go_idle();
                return;
            end
            cyc_ms = cyc_ms + reg_interval * MS_PER_SEC;
            if (clk_ms > cyc_ms) cyc_ms = clk_ms;
            due_ms = cyc_ms;
        end else begin
            k = idx[2:0];
            due_ms = (tab_rel[k] ? clk_ms : cyc_ms) + tab_off[k];
        end
    endfunction

    function automatic void ask_stop();
        if (at_lead_in || stop_req) begin
            go_idle();
        end else begin
            stop_req = 1'b1;
            res_now.event_res = EV_PENDING;
        end
    endfunction

    function automatic result_t next_result(item_t it);
        logic [MS_W-1:0] since;
        logic [63:0]     lim;
        res_now = '0;
        case (it.op)
            OP_TICK: begin
                clk_ms = clk_ms + 1;
                if (active) begin
                    since = clk_ms - run_start_ms;
                    lim   = reg_duration * 64'd1000;
                    if (reg_duration != 0 && {32'd0, since} >= lim) ask_stop();
                    else if (clk_ms >= due_ms) step_ahead();
                end
            end
            OP_START: begin
                if (steps_used() == 0) begin
                    go_idle();
                end else begin
                    at_lead_in   = 1'b1;
                    pos          = '0;
                    run_start_ms = clk_ms;
                    cyc_ms       = clk_ms;
                    due_ms       = clk_ms;
                    shots        = '0;
                    active       = 1'b1;
                    stop_req     = 1'b0;
                    step_ahead();
                end
            end
            OP_STOP: begin
                if (active) ask_stop();
                else go_idle();
            end
            default: begin
                tab_off[it.slot] = it.entry.offset_ms;
                tab_rel[it.slot] = it.entry.relative;
            end
        endcase
        res_now.running    = active;
        res_now.stopping   = stop_req;
        res_now.shots_done = shots;
        res_now.ms_to_next = (active && clk_ms < due_ms) ? due_ms - clk_ms : '0;
        return res_now;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic plan_row_t cmd_row(opcode_t op, logic [2:0] slot, logic [31:0] offs,
                                          logic rel, bit typed, event_t ev);
        plan_row_t r;
        r.cfg_row = 1'b0;
        r.intv    = '0;
        r.dur     = '0;
        r.reps    = '0;
        r.steps   = '0;
        r.cmd.op  = op;
        r.cmd.slot = slot;
        r.cmd.entry.offset_ms = offs;
        r.cmd.entry.relative  = rel;
        r.typed   = typed;
        r.want    = '0;
        r.want.event_res = ev;
        return r;
    endfunction

    function automatic plan_row_t cfg_row(logic [INTERVAL_W-1:0] intv,
                                          logic [DURATION_W-1:0] dur,
                                          logic [REPS_W-1:0] reps, logic [STEPS_W-1:0] steps);
        plan_row_t r;
        r.cfg_row = 1'b1;
        r.intv    = intv;
        r.dur     = dur;
        r.reps    = reps;
        r.steps   = steps;
        r.cmd     = '0;
        r.typed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    // Mostly ticks; noisy items also restart, stop and reload the table
    function automatic item_t rand_item(bit noisy);
        item_t       it;
        int unsigned r;
        int unsigned r2;
        r  = $urandom_range(0, 99);
        r2 = $urandom_range(0, 99);
        it.slot = 3'($urandom_range(0, 7));
        it.entry.relative = 1'($urandom_range(0, 1));
        if (r2 < 70)      it.entry.offset_ms = $urandom_range(0, 5);
        else if (r2 < 80) it.entry.offset_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
        else if (r2 < 90) it.entry.offset_ms = $urandom_range(0, 1500);
        else              it.entry.offset_ms = $urandom;
        if (!noisy || r < 84) it.op = OP_TICK;
        else if (r < 87)      it.op = OP_START;
        else if (r < 91)      it.op = OP_STOP;
        else                  it.op = OP_LOAD;
        return it;
    endfunction

    function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Offer one transaction after a random gap; predict once it is taken
    task automatic push_item(item_t it, bit typed, result_t want);
        result_t calc;
        while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= {4'b0, it.entry.relative, it.entry.offset_ms, it.slot};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        calc = next_result(it);
        results_due.push_back(typed ? want : calc);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic configure(logic [INTERVAL_W-1:0] intv, logic [DURATION_W-1:0] dur,
                             logic [REPS_W-1:0] reps, logic [STEPS_W-1:0] steps);
        write_reg(REG_INTERVAL, intv);
        write_reg(REG_DURATION, dur);
        write_reg(REG_REPS, reps);
        write_reg(REG_STEPS, steps);
        cfg_wr_en <= 1'b0;
        reg_interval = intv;
        reg_duration = dur;
        reg_reps     = reps;
        reg_steps    = steps;
    endtask

    // Reconfigure, reload all slots, start, then run a stretch of traffic
    task automatic run_phase(logic [INTERVAL_W-1:0] intv, logic [DURATION_W-1:0] dur,
                             logic [REPS_W-1:0] reps, logic [STEPS_W-1:0] steps,
                             int unsigned max_off, int unsigned count, bit noisy, bit squeeze);
        item_t ld;
        settle();
        configure(intv, dur, reps, steps);
        for (int k = 0; k < SLOT_LIMIT; k++) begin
            ld.op   = OP_LOAD;
            ld.slot = k[2:0];
            ld.entry.offset_ms = $urandom_range(0, max_off);
            ld.entry.relative  = 1'($urandom_range(0, 1));
            push_item(ld, 1'b0, '0);
        end
        ld = rand_item(1'b0);
        ld.op = OP_START;
        push_item(ld, 1'b0, '0);
        if (squeeze) hold_asks++;
        repeat (count) push_item(rand_item(noisy), 1'b0, '0);
    endtask

    // ---------------- result side ----------------

    initial begin : result_side
        result_t got;
        result_t want;
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) begin
                got.fired      = m_tdata[0];
                got.fired_step = m_tdata[3:1];
                got.running    = m_tdata[4];
                got.stopping   = m_tdata[5];
                got.shots_done = m_tdata[21:6];
                got.ms_to_next = m_tdata[53:22];
                got.event_res  = event_t'(m_tuser);
                if (results_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing outstanding, expected none, got %h %h",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = results_due.pop_front();
                    field_check("fired", want.fired, got.fired);
                    field_check("fired_step", want.fired_step, got.fired_step);
                    field_check("running", want.running, got.running);
                    field_check("stopping", want.stopping, got.stopping);
                    field_check("event_res", want.event_res, got.event_res);
                    field_check("shots_done", want.shots_done, got.shots_done);
                    field_check("ms_to_next", want.ms_to_next, got.ms_to_next);
                end
            end
            // Hold off for a long stretch on request, else stall at random
            if (hold_seen != hold_asks) begin
                hold_left = HOLD_CYCLES;
                hold_seen = hold_asks;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ---------------- watchdog ----------------

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ---------------- stimulus ----------------

    initial begin : stimulus
        logic [INTERVAL_W-1:0] intv;
        logic [REPS_W-1:0]     reps;
        logic [STEPS_W-1:0]    steps;

        // Directed table: reset-state answers typed in, running rows predicted
        plan = '{
            cmd_row(OP_TICK,  3'd0, 32'd0,         1'b0, 1'b1, EV_NONE),
            cmd_row(OP_STOP,  3'd7, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_STOPPED),
            cmd_row(OP_START, 3'd0, 32'd0,         1'b0, 1'b1, EV_STOPPED),
            cmd_row(OP_LOAD,  3'd0, 32'd0,         1'b0, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd1, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd2, 32'd2,         1'b1, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd3, 32'hFFFF_FFFF, 1'b0, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd4, 32'd1,         1'b0, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd5, 32'd3,         1'b1, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd6, 32'd0,         1'b1, 1'b1, EV_NONE),
            cmd_row(OP_LOAD,  3'd7, 32'd5,         1'b0, 1'b1, EV_NONE),
            // one cycle of three steps; the last step fires and stops in one item
            cfg_row(17'd0, 23'd0, 16'd1, 4'd3),
            cmd_row(OP_START, 3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            // stop pending, stop again, restart while running
            cfg_row(17'd0, 23'd0, 16'd0, 4'd8),
            cmd_row(OP_START, 3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_STOP,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_STOP,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_START, 3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_START, 3'd0, 32'd0, 1'b0, 1'b0, EV_NONE),
            cmd_row(OP_TICK,  3'd0, 32'd0, 1'b0, 1'b0, EV_NONE)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].cfg_row) begin
                settle();
                configure(plan[i].intv, plan[i].dur, plan[i].reps, plan[i].steps);
            end else begin
                push_item(plan[i].cmd, plan[i].typed, plan[i].want);
            end
        end

        // Register extremes, then an empty step list
        run_phase(17'd86400, 23'd4294967, 16'd65535, 4'd15, 4, 60, 1'b1, 1'b0);
        run_phase(17'd0, 23'd0, 16'd0, 4'd0, 4, 30, 1'b1, 1'b0);

        // Random settings with mixed traffic; two phases stall the result side
        for (int ph = 0; ph < 6; ph++) begin
            intv  = ($urandom_range(0, 9) == 0) ? 17'd1 : 17'd0;
            reps  = 16'($urandom_range(0, 4));
            steps = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(1, 8));
            run_phase(intv, 23'd0, reps, steps, 4, 40, 1'b1, ph == 1 || ph == 4);
        end

        // One-second interval under a one-second duration limit, with no idling
        idle_on = 1'b0;
        run_phase(17'd1, 23'd1, 16'd0, 4'd3, 1500, 1030, 1'b0, 1'b0);

        settle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
